FILE: rtl/core/tpm_pkg.sv
// tpm_pkg: shared types and codes for the tree parity machine step block.
// Depends on nothing; imported by tree_parity_machine_step and tpm_alu.
package tpm_pkg;

	localparam logic [1:0] MODE_COMPUTE = 2'd0;
	localparam logic [1:0] MODE_PARTNER = 2'd1;
	localparam logic [1:0] MODE_LOAD    = 2'd2;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 7;

	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_LIMIT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ZERO_AS_PLUS = 1'd1;

	localparam logic [CFG_DATA_W-1:0] WEIGHT_LIMIT_RST = 7'd3;

	typedef struct packed {
		logic [1:0]        mode;
		logic [15:0]       input_bits;
		logic              partner_output;
		logic [5:0]        weight_index;
		logic signed [7:0] weight_value;
	} in_item_t;

	typedef struct packed {
		logic       own_output;
		logic [2:0] hidden_signs;
		logic       weights_updated;
	} out_item_t;

	// sequencer to arithmetic unit
	typedef struct packed {
		logic acc_en;
		logic first;
		logic xbit;
		logic load_sel;
		logic par_bit;
	} alu_ctrl_t;

endpackage

FILE: rtl/core/tree_parity_machine_step.sv
// tree_parity_machine_step: K hidden units of N weights, one shared add/clamp unit.
// Compute and agreeing-partner words walk all K*N weights, then pass a drain state before the result.
// Other partner words and mode 3 go straight to the result; a weight load passes a load state. One word in flight,
// next taken from the cycle in which the result is raised; raising it waits for a free output register.
// After reset a clearing sweep zeroes all K*N weights; no word is taken meanwhile.
// Depends on tpm_pkg, tpm_wmem, tpm_alu.
module tree_parity_machine_step #(
	parameter int HIDDEN_UNITS    = 3,
	parameter int INPUTS_PER_UNIT = 16,
	parameter int WEIGHT_WIDTH    = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  tpm_pkg::in_item_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output tpm_pkg::out_item_t               out_data,
	input  logic                             cfg_we,
	input  logic [tpm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tpm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tpm_pkg::*;

	localparam int TOTAL = HIDDEN_UNITS * INPUTS_PER_UNIT;
	localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int NW    = (INPUTS_PER_UNIT > 1) ? $clog2(INPUTS_PER_UNIT) : 1;
	localparam int KW    = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
	localparam int SW    = WEIGHT_WIDTH + NW + 1;

	localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL - 1);
	localparam logic [NW-1:0] LAST_N    = NW'(INPUTS_PER_UNIT - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_LOAD  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]              state_q;
	in_item_t                item_q;
	logic                    upd_q;
	logic [AW-1:0]           addr_q;
	logic [NW-1:0]           n_q;
	logic [KW-1:0]           k_q;
	logic [CFG_DATA_W-1:0]   limit_q;
	logic                    zap_q;
	logic [HIDDEN_UNITS-1:0] signs_q;
	logic                    parity_q;
	logic [15:0]             stored_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	logic                    v_s1;
	logic                    first_s1;
	logic                    last_s1;
	logic                    x_s1;
	logic                    ue_s1;
	logic [KW-1:0]           k_s1;
	logic [AW-1:0]           addr_s1;

	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [WEIGHT_WIDTH-1:0] mem_wdata;
	logic [WEIGHT_WIDTH-1:0] mem_rdata;
	logic signed [WEIGHT_WIDTH-1:0] alu_wr;
	logic                    alu_plus;
	alu_ctrl_t               alu_ctrl;

	logic                    ld_ok;
	logic [6:0]              n_ext;
	logic [15:0]             x_src;
	logic                    x_issue;
	logic [HIDDEN_UNITS-1:0] match;
	logic                    par_new;
	logic [HIDDEN_UNITS+2:0] signs_pad;
	logic                    is_compute;
	logic                    is_partner;

	assign is_compute = (item_q.mode == MODE_COMPUTE);
	assign is_partner = (item_q.mode == MODE_PARTNER);
	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	always_comb begin
		ld_ok   = (32'(item_q.weight_index) < TOTAL);
		n_ext   = 7'(n_q);
		x_src   = is_compute ? item_q.input_bits : stored_q;
		x_issue = (n_ext < 7'd16) ? x_src[n_ext[3:0]] : 1'b0;
		match   = parity_q ? signs_q : ~signs_q;
		par_new = ~(^(~signs_q));
		signs_pad = (HIDDEN_UNITS + 3)'(signs_q);
	end

	always_comb begin
		alu_ctrl.acc_en   = v_s1 && is_compute;
		alu_ctrl.first    = first_s1;
		alu_ctrl.xbit     = x_s1;
		alu_ctrl.load_sel = (state_q == ST_LOAD);
		alu_ctrl.par_bit  = parity_q;
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = addr_q;
			mem_wdata = '0;
		end else if (state_q == ST_LOAD) begin
			mem_we    = ld_ok;
			mem_waddr = AW'(item_q.weight_index);
			mem_wdata = alu_wr;
		end else begin
			mem_we    = v_s1 && is_partner && ue_s1;
			mem_waddr = addr_s1;
			mem_wdata = alu_wr;
		end
	end

	tpm_wmem #(
		.DEPTH (TOTAL),
		.WIDTH (WEIGHT_WIDTH),
		.AW    (AW)
	) u_wmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	tpm_alu #(
		.WW (WEIGHT_WIDTH),
		.SW (SW)
	) u_alu (
		.clk       (clk),
		.ctrl      (alu_ctrl),
		.w         ($signed(mem_rdata)),
		.ld_val    (item_q.weight_value),
		.limit     (limit_q),
		.zap       (zap_q),
		.wr_data   (alu_wr),
		.sign_plus (alu_plus)
	);

	always_ff @(posedge clk) begin
		first_s1 <= (n_q == '0);
		last_s1  <= (n_q == LAST_N);
		x_s1     <= x_issue;
		ue_s1    <= (signs_q[k_q] == parity_q);
		k_s1     <= k_q;
		addr_s1  <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= WEIGHT_LIMIT_RST;
			zap_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WEIGHT_LIMIT: limit_q <= cfg_data;
				REG_ZERO_AS_PLUS: zap_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			item_q      <= '0;
			upd_q       <= 1'b0;
			addr_q      <= '0;
			n_q         <= '0;
			k_q         <= '0;
			signs_q     <= '0;
			parity_q    <= 1'b1;
			stored_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			v_s1        <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_RUN);
			if (v_s1 && last_s1 && is_compute) begin
				signs_q[k_s1] <= alu_plus;
			end
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						addr_q <= '0;
						n_q    <= '0;
						k_q    <= '0;
						upd_q  <= 1'b0;
						unique case (in_data.mode)
							MODE_COMPUTE: begin
								stored_q <= in_data.input_bits;
								state_q  <= ST_RUN;
							end
							MODE_PARTNER: begin
								if ((in_data.partner_output == parity_q) && (|match)) begin
									upd_q   <= 1'b1;
									state_q <= ST_RUN;
								end else begin
									state_q <= ST_DONE;
								end
							end
							MODE_LOAD: state_q <= ST_LOAD;
							default:   state_q <= ST_DONE;
						endcase
					end
				end
				ST_RUN: begin
					addr_q <= addr_q + AW'(1);
					if (n_q == LAST_N) begin
						n_q <= '0;
						k_q <= k_q + KW'(1);
					end else begin
						n_q <= n_q + NW'(1);
					end
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_DONE;
				ST_LOAD:  state_q <= ST_DONE;
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q           <= 1'b1;
						out_q.own_output      <= is_compute ? par_new : parity_q;
						out_q.hidden_signs    <= signs_pad[2:0];
						out_q.weights_updated <= upd_q;
						if (is_compute) begin
							parity_q <= par_new;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_run_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && addr_q == LAST_ADDR) |=> (state_q == ST_DRAIN))
		else $error("weight walk did not end at last address");

	a_s1_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("stage 1 valid outside weight walk");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result word raised outside done state");

	a_upd_partner: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && (state_q == ST_RUN || state_q == ST_DRAIN) |-> (upd_q && is_partner))
		else $error("weight written in walk without agreed update");
`endif

endmodule

FILE: rtl/core/tpm_wmem.sv
// tpm_wmem: weight memory, one write port and one registered read port.
// Depends on nothing.
module tpm_wmem #(
	parameter int DEPTH = 48,
	parameter int WIDTH = 8,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/tpm_alu.sv
// tpm_alu: shared unit: weighted-sum accumulator, sign decision, weight step and clamp.
// Depends on tpm_pkg.
module tpm_alu #(
	parameter int WW = 8,
	parameter int SW = 13
) (
	input  logic                             clk,
	input  tpm_pkg::alu_ctrl_t               ctrl,
	input  logic signed [WW-1:0]             w,
	input  logic signed [7:0]                ld_val,
	input  logic [tpm_pkg::CFG_DATA_W-1:0]   limit,
	input  logic                             zap,
	output logic signed [WW-1:0]             wr_data,
	output logic                             sign_plus
);
	import tpm_pkg::*;

	localparam int CW   = ((WW > 8) ? WW : 8) + 2;
	localparam int WMAX = (2 ** (WW - 1)) - 1;

	logic signed [CW-1:0] bnd;
	logic signed [CW-1:0] w_sx;
	logic signed [CW-1:0] opnd;
	logic signed [CW-1:0] clamped;
	logic signed [SW-1:0] term;
	logic signed [SW-1:0] acc_q;
	logic signed [SW-1:0] acc_next;

	always_comb begin
		bnd = (32'(limit) < WMAX) ? CW'(limit) : CW'(WMAX);
		w_sx = CW'(w);
		if (ctrl.load_sel) begin
			opnd = CW'(ld_val);
		end else if (ctrl.par_bit == ctrl.xbit) begin
			opnd = w_sx - CW'(1);
		end else begin
			opnd = w_sx + CW'(1);
		end
		if (opnd > bnd) begin
			clamped = bnd;
		end else if (opnd < -bnd) begin
			clamped = -bnd;
		end else begin
			clamped = opnd;
		end
		wr_data = WW'(clamped);
	end

	always_comb begin
		term = ctrl.xbit ? SW'(w) : -SW'(w);
		acc_next = (ctrl.first ? SW'(0) : acc_q) + term;
		sign_plus = (acc_next > SW'(0)) || ((acc_next == SW'(0)) && zap);
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc_en) begin
			acc_q <= acc_next;
		end
	end

endmodule
